>>> rtl/rpms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose mode sequencer package
// Shared codes, field widths and types for the pose mode sequencer.
// ----------------------------------------------------------------------------
package rpms_pkg;

	// field widths fixed by the item format
	localparam int CODE_W  = 4;
	localparam int JNUM_W  = 5;
	localparam int STIFF_W = 4;
	localparam int DAMP_W  = 3;
	localparam int MODE_W  = 3;
	localparam int TICK_W  = 16;
	localparam int FRAC_W  = 17;

	// input item codes
	localparam logic [CODE_W-1:0] IN_TICK       = 4'd0;
	localparam logic [CODE_W-1:0] IN_REPORT     = 4'd1;
	localparam logic [CODE_W-1:0] IN_LOAD_LIE   = 4'd2;
	localparam logic [CODE_W-1:0] IN_LOAD_STAND = 4'd3;
	localparam logic [CODE_W-1:0] IN_START      = 4'd4;
	localparam logic [CODE_W-1:0] IN_SWITCH     = 4'd5;
	localparam logic [CODE_W-1:0] IN_WALK       = 4'd6;
	localparam logic [CODE_W-1:0] IN_DANCE      = 4'd7;
	localparam logic [CODE_W-1:0] IN_WALK12     = 4'd8;
	localparam logic [CODE_W-1:0] IN_JUMP13     = 4'd9;
	localparam logic [CODE_W-1:0] IN_POSITION   = 4'd10;
	localparam logic [CODE_W-1:0] IN_ESTOP      = 4'd11;

	// robot modes
	localparam logic [MODE_W-1:0] M_DEFAULT = 3'd0;
	localparam logic [MODE_W-1:0] M_LIE     = 3'd1;
	localparam logic [MODE_W-1:0] M_STAND   = 3'd2;
	localparam logic [MODE_W-1:0] M_WALK    = 3'd3;
	localparam logic [MODE_W-1:0] M_DANCE   = 3'd4;
	localparam logic [MODE_W-1:0] M_WALK12  = 3'd5;
	localparam logic [MODE_W-1:0] M_JUMP13  = 3'd6;

	// classified operation kinds
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOCK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LOCK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_LOCK  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INC    = 2'd3;

	localparam logic [TICK_W-1:0] RST_START_LOCK  = 16'd250;
	localparam logic [TICK_W-1:0] RST_SWITCH_LOCK = 16'd400;
	localparam logic [TICK_W-1:0] RST_OTHER_LOCK  = 16'd100;
	localparam logic [FRAC_W-1:0] RST_RAMP_INC    = 17'd66;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
	localparam logic [TICK_W-1:0] TICK_SAT = 16'hFFFF;

	// command gains
	localparam logic [STIFF_W-1:0] STIFF_ON     = 4'd10;
	localparam logic [STIFF_W-1:0] STIFF_OFF    = 4'd0;
	localparam logic [DAMP_W-1:0]  DAMP_DEFAULT = 3'd1;
	localparam logic [DAMP_W-1:0]  DAMP_ANKLE   = 3'd2;
	localparam logic [DAMP_W-1:0]  DAMP_BODY    = 3'd5;
	localparam logic [DAMP_W-1:0]  DAMP_NONE    = 3'd0;
	localparam int ANKLE_ROLL_L = 19;
	localparam int ANKLE_ROLL_R = 20;

	// queue depths
	localparam int FRONT_DEPTH = 4;
	localparam int FRONT_PTR_W = 2;
	localparam int OUTQ_DEPTH  = 8;
	localparam int OUTQ_PTR_W  = 3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
		logic [JNUM_W-1:0] joint;
	} op_t;

	// everything of a result but the target angle
	typedef struct packed {
		logic               is_status;
		logic [JNUM_W-1:0]  joint_number;
		logic [STIFF_W-1:0] stiffness;
		logic [DAMP_W-1:0]  damping_tenths;
		logic               last_of_run;
		logic [MODE_W-1:0]  current_mode;
		logic               control_enabled;
		logic               restart_policy;
		logic               clear_velocity_command;
	} meta_t;

endpackage

>>> rtl/rpms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose mode sequencer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rpms_in_if #(parameter int ANGLE_BITS = 16);
	logic                                valid;
	logic                                ready;
	logic [rpms_pkg::CODE_W-1:0]         mode;
	logic [rpms_pkg::JNUM_W-1:0]         joint_index;
	logic signed [ANGLE_BITS-1:0]        angle_value;

	modport source (output valid, output mode, output joint_index, output angle_value,
		input ready);
	modport sink (input valid, input mode, input joint_index, input angle_value,
		output ready);
endinterface

interface rpms_out_if #(parameter int ANGLE_BITS = 16);
	logic                                valid;
	logic                                ready;
	logic                                is_status;
	logic [rpms_pkg::JNUM_W-1:0]         joint_number;
	logic signed [ANGLE_BITS-1:0]        target_angle;
	logic [rpms_pkg::STIFF_W-1:0]        stiffness;
	logic [rpms_pkg::DAMP_W-1:0]         damping_tenths;
	logic                                last_of_run;
	logic [rpms_pkg::MODE_W-1:0]         current_mode;
	logic                                control_enabled;
	logic                                restart_policy;
	logic                                clear_velocity_command;

	modport source (output valid, output is_status, output joint_number,
		output target_angle, output stiffness, output damping_tenths,
		output last_of_run, output current_mode, output control_enabled,
		output restart_policy, output clear_velocity_command, input ready);
	modport sink (input valid, input is_status, input joint_number,
		input target_angle, input stiffness, input damping_tenths,
		input last_of_run, input current_mode, input control_enabled,
		input restart_policy, input clear_velocity_command, output ready);
endinterface

>>> rtl/rpms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rpms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose mode sequencer front end
// Accepts input items, sorts them into ticks, table writes and events,
// drops what has no effect and queues the rest for the back end.
// ----------------------------------------------------------------------------
module rpms_front #(
	parameter int JOINT_COUNT = 21,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rpms_in_if.sink                      events,
	output logic                         op_valid,
	input  logic                         op_ready,
	output rpms_pkg::op_t                op,
	output logic signed [ANGLE_BITS-1:0] op_angle
);

	rpms_pkg::op_t                q_op_q  [rpms_pkg::FRONT_DEPTH];
	logic signed [ANGLE_BITS-1:0] q_ang_q [rpms_pkg::FRONT_DEPTH];
	logic [rpms_pkg::FRONT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rpms_pkg::FRONT_PTR_W:0]   cnt_q;

	rpms_pkg::op_t cls;
	logic          keep;
	logic          push, pop;

	always_comb begin
		cls       = '0;
		keep      = 1'b0;
		cls.code  = events.mode;
		cls.joint = events.joint_index;
		priority if (events.mode == rpms_pkg::IN_TICK) begin
			cls.kind = rpms_pkg::OP_TICK;
			keep     = 1'b1;
		end else if (events.mode == rpms_pkg::IN_REPORT ||
				events.mode == rpms_pkg::IN_LOAD_LIE ||
				events.mode == rpms_pkg::IN_LOAD_STAND) begin
			cls.kind = rpms_pkg::OP_WRITE;
			// writes beyond the last joint are dropped here
			keep     = 32'(events.joint_index) < 32'(JOINT_COUNT);
		end else if (events.mode >= rpms_pkg::IN_START &&
				events.mode <= rpms_pkg::IN_ESTOP) begin
			cls.kind = rpms_pkg::OP_EVENT;
			keep     = 1'b1;
		end else begin
			// unused codes give nothing
			keep     = 1'b0;
		end
	end

	assign events.ready = cnt_q != (rpms_pkg::FRONT_PTR_W + 1)'(rpms_pkg::FRONT_DEPTH);
	assign push         = events.valid && events.ready && keep;
	assign op_valid     = cnt_q != '0;
	assign pop          = op_valid && op_ready;
	assign op           = q_op_q[rd_ptr_q];
	assign op_angle     = q_ang_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_op_q[wr_ptr_q]  <= cls;
			q_ang_q[wr_ptr_q] <= events.angle_value;
		end
	end

endmodule

>>> rtl/rpms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose mode sequencer back end
// Holds the mode state and the joint tables, carries out queued operations,
// sweeps the joints on a tick through a blend pipeline and buffers results.
// ----------------------------------------------------------------------------
module rpms_back #(
	parameter int JOINT_COUNT = 21,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rpms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpms_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                op_valid,
	output logic                                op_ready,
	input  rpms_pkg::op_t                       op,
	input  logic signed [ANGLE_BITS-1:0]        op_angle,
	rpms_out_if.source                          commands
);

	localparam int JW = $clog2(JOINT_COUNT);
	localparam logic [JW-1:0] J_LAST = JW'(JOINT_COUNT - 1);
	localparam int PW = ANGLE_BITS + 19;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_COPY = 2'd2;

	// configuration
	logic [rpms_pkg::TICK_W-1:0] start_lock_q, switch_lock_q, other_lock_q;
	logic [rpms_pkg::FRAC_W-1:0] ramp_inc_q;

	// mode state
	logic [rpms_pkg::MODE_W-1:0] mode_q;
	logic                        enabled_q, estop_q;
	logic [rpms_pkg::FRAC_W-1:0] frac_q;
	logic [rpms_pkg::TICK_W-1:0] ticks_q;
	logic [JOINT_COUNT-1:0]      live_valid_q, start_valid_q;

	// sequencer
	logic [1:0]                  st_q;
	logic [JW-1:0]               j_q;
	logic [rpms_pkg::MODE_W-1:0] loop_mode_q;
	logic                        loop_blend_q, loop_stand_q;
	logic [rpms_pkg::FRAC_W-1:0] loop_frac_q;

	// pipeline
	logic                         v_s1, v_s2, v_s3;
	rpms_pkg::meta_t              meta_s1, meta_s2, meta_s3;
	logic                         blend_s1, stand_s1;
	logic [JW-1:0]                j_s1;
	logic [rpms_pkg::FRAC_W-1:0]  f_s1, f_s2;
	logic signed [ANGLE_BITS-1:0] a_s2, a_s3;
	logic signed [ANGLE_BITS:0]   d_s2;
	logic signed [PW-1:0]         p_s3;
	logic                         cp_v_s1;
	logic [JW-1:0]                cp_addr_s1;

	// output queue
	rpms_pkg::meta_t               oq_meta_q [rpms_pkg::OUTQ_DEPTH];
	logic [ANGLE_BITS-1:0]         oq_tgt_q  [rpms_pkg::OUTQ_DEPTH];
	logic [rpms_pkg::OUTQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic [rpms_pkg::OUTQ_PTR_W:0]   oq_cnt_q;

	logic [ANGLE_BITS-1:0] live_rd, start_rd, lie_rd, stand_rd;
	logic                  slot_free, take, issue_tick, issue_status, oq_pop;
	logic [rpms_pkg::OUTQ_PTR_W+2:0] in_flight;

	logic [rpms_pkg::TICK_W-1:0] lock;
	logic                        pass, ev_en, ev_rs, ev_cv, ev_snap, ev_zero;
	logic [rpms_pkg::MODE_W-1:0] ev_mode;
	logic                        tick_moves, tick_emits;
	logic [rpms_pkg::FRAC_W:0]   frac_sum;
	logic [rpms_pkg::FRAC_W-1:0] frac_next;
	rpms_pkg::meta_t             stat_meta, tick_meta;
	logic signed [ANGLE_BITS-1:0] a_sel, b_sel;
	logic [PW-1:0]               tgt_sum;
	logic                        ankle;

	// memories
	rpms_ram #(.WIDTH(ANGLE_BITS), .DEPTH(JOINT_COUNT)) u_live (
		.clk  (clk),
		.we   (take && op.kind == rpms_pkg::OP_WRITE && op.code == rpms_pkg::IN_REPORT),
		.waddr(JW'(op.joint)),
		.wdata(op_angle),
		.raddr(j_q),
		.rdata(live_rd)
	);

	rpms_ram #(.WIDTH(ANGLE_BITS), .DEPTH(JOINT_COUNT)) u_start (
		.clk  (clk),
		.we   (cp_v_s1),
		.waddr(cp_addr_s1),
		.wdata(live_rd),
		.raddr(j_q),
		.rdata(start_rd)
	);

	rpms_ram #(.WIDTH(ANGLE_BITS), .DEPTH(JOINT_COUNT)) u_lie (
		.clk  (clk),
		.we   (take && op.kind == rpms_pkg::OP_WRITE && op.code == rpms_pkg::IN_LOAD_LIE),
		.waddr(JW'(op.joint)),
		.wdata(op_angle),
		.raddr(j_q),
		.rdata(lie_rd)
	);

	rpms_ram #(.WIDTH(ANGLE_BITS), .DEPTH(JOINT_COUNT)) u_stand (
		.clk  (clk),
		.we   (take && op.kind == rpms_pkg::OP_WRITE &&
			op.code == rpms_pkg::IN_LOAD_STAND),
		.waddr(JW'(op.joint)),
		.wdata(op_angle),
		.raddr(j_q),
		.rdata(stand_rd)
	);

	// room for everything in flight before a new result is issued
	assign in_flight = (rpms_pkg::OUTQ_PTR_W + 3)'(oq_cnt_q) +
		(rpms_pkg::OUTQ_PTR_W + 3)'(v_s1) + (rpms_pkg::OUTQ_PTR_W + 3)'(v_s2) +
		(rpms_pkg::OUTQ_PTR_W + 3)'(v_s3);
	assign slot_free    = in_flight < (rpms_pkg::OUTQ_PTR_W + 3)'(rpms_pkg::OUTQ_DEPTH);
	assign op_ready     = st_q == ST_IDLE && slot_free;
	assign take         = op_valid && op_ready;
	assign issue_tick   = st_q == ST_TICK && slot_free;
	assign issue_status = take && op.kind == rpms_pkg::OP_EVENT;

	// event decode
	always_comb begin
		lock = other_lock_q;
		if (op.code == rpms_pkg::IN_START) begin
			lock = start_lock_q;
		end else if (op.code == rpms_pkg::IN_SWITCH) begin
			lock = switch_lock_q;
		end
		pass    = op.code != rpms_pkg::IN_ESTOP && ticks_q > lock;
		ev_mode = mode_q;
		ev_en   = enabled_q;
		ev_rs   = 1'b0;
		ev_cv   = 1'b0;
		ev_snap = 1'b0;
		ev_zero = 1'b0;
		if (pass) begin
			unique case (op.code)
				rpms_pkg::IN_START: begin
					if (!enabled_q) begin
						ev_en   = 1'b1;
						ev_zero = 1'b1;
						ev_snap = 1'b1;
						ev_mode = rpms_pkg::M_LIE;
					end else begin
						ev_en   = 1'b0;
						ev_mode = rpms_pkg::M_DEFAULT;
					end
				end
				rpms_pkg::IN_SWITCH: begin
					if (enabled_q && mode_q == rpms_pkg::M_STAND) begin
						ev_zero = 1'b1;
						ev_snap = 1'b1;
						ev_mode = rpms_pkg::M_LIE;
					end else if (enabled_q && mode_q == rpms_pkg::M_LIE) begin
						ev_zero = 1'b1;
						ev_mode = rpms_pkg::M_STAND;
					end
				end
				rpms_pkg::IN_WALK: begin
					if (mode_q == rpms_pkg::M_STAND || mode_q == rpms_pkg::M_WALK12 ||
							mode_q == rpms_pkg::M_JUMP13) begin
						ev_mode = rpms_pkg::M_WALK;
						ev_rs   = 1'b1;
					end else if (mode_q == rpms_pkg::M_DANCE) begin
						ev_mode = rpms_pkg::M_WALK;
						ev_rs   = 1'b1;
						ev_cv   = 1'b1;
					end
				end
				rpms_pkg::IN_DANCE: begin
					if (enabled_q && (mode_q == rpms_pkg::M_STAND ||
							mode_q == rpms_pkg::M_WALK || mode_q == rpms_pkg::M_WALK12 ||
							mode_q == rpms_pkg::M_JUMP13)) begin
						ev_mode = rpms_pkg::M_DANCE;
						ev_rs   = 1'b1;
						ev_cv   = 1'b1;
					end
				end
				rpms_pkg::IN_WALK12: begin
					if (mode_q == rpms_pkg::M_STAND || mode_q == rpms_pkg::M_WALK ||
							mode_q == rpms_pkg::M_JUMP13) begin
						ev_mode = rpms_pkg::M_WALK12;
						ev_rs   = 1'b1;
					end
				end
				rpms_pkg::IN_JUMP13: begin
					if (mode_q == rpms_pkg::M_STAND || mode_q == rpms_pkg::M_WALK ||
							mode_q == rpms_pkg::M_WALK12) begin
						ev_mode = rpms_pkg::M_JUMP13;
						ev_rs   = 1'b1;
					end
				end
				rpms_pkg::IN_POSITION: begin
					if (mode_q == rpms_pkg::M_WALK || mode_q == rpms_pkg::M_WALK12 ||
							mode_q == rpms_pkg::M_JUMP13) begin
						ev_mode = rpms_pkg::M_STAND;
					end else if (mode_q == rpms_pkg::M_DANCE) begin
						ev_mode = rpms_pkg::M_WALK;
						ev_rs   = 1'b1;
						ev_cv   = 1'b1;
					end else if (mode_q == rpms_pkg::M_DEFAULT) begin
						ev_zero = 1'b1;
						ev_snap = 1'b1;
						ev_mode = rpms_pkg::M_LIE;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat_meta                        = '0;
		stat_meta.is_status              = 1'b1;
		stat_meta.last_of_run            = 1'b1;
		stat_meta.current_mode           = ev_mode;
		stat_meta.control_enabled        = ev_en;
		stat_meta.restart_policy         = ev_rs;
		stat_meta.clear_velocity_command = ev_cv;
	end

	assign tick_moves = mode_q == rpms_pkg::M_LIE || mode_q == rpms_pkg::M_STAND;
	assign tick_emits = tick_moves || mode_q == rpms_pkg::M_DEFAULT;
	assign frac_sum   = {1'b0, frac_q} + {1'b0, ramp_inc_q};
	assign frac_next  = frac_sum > {1'b0, rpms_pkg::FRAC_ONE} ? rpms_pkg::FRAC_ONE :
		frac_sum[rpms_pkg::FRAC_W-1:0];

	assign ankle = 32'(j_q) == 32'(rpms_pkg::ANKLE_ROLL_L) ||
		32'(j_q) == 32'(rpms_pkg::ANKLE_ROLL_R);

	always_comb begin
		tick_meta                 = '0;
		tick_meta.joint_number    = rpms_pkg::JNUM_W'(j_q);
		tick_meta.stiffness       = loop_blend_q ? rpms_pkg::STIFF_ON : rpms_pkg::STIFF_OFF;
		tick_meta.damping_tenths  = !loop_blend_q ? rpms_pkg::DAMP_DEFAULT :
			(ankle ? rpms_pkg::DAMP_ANKLE : rpms_pkg::DAMP_BODY);
		tick_meta.last_of_run     = j_q == J_LAST;
		tick_meta.current_mode    = loop_mode_q;
		tick_meta.control_enabled = enabled_q;
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_lock_q  <= rpms_pkg::RST_START_LOCK;
			switch_lock_q <= rpms_pkg::RST_SWITCH_LOCK;
			other_lock_q  <= rpms_pkg::RST_OTHER_LOCK;
			ramp_inc_q    <= rpms_pkg::RST_RAMP_INC;
			mode_q        <= rpms_pkg::M_DEFAULT;
			enabled_q     <= 1'b0;
			estop_q       <= 1'b0;
			frac_q        <= '0;
			ticks_q       <= rpms_pkg::TICK_SAT;
			live_valid_q  <= '0;
			start_valid_q <= '0;
			st_q          <= ST_IDLE;
			j_q           <= '0;
			loop_mode_q   <= rpms_pkg::M_DEFAULT;
			loop_blend_q  <= 1'b0;
			loop_stand_q  <= 1'b0;
			loop_frac_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					rpms_pkg::CFG_START_LOCK:  start_lock_q  <= cfg_data[rpms_pkg::TICK_W-1:0];
					rpms_pkg::CFG_SWITCH_LOCK: switch_lock_q <= cfg_data[rpms_pkg::TICK_W-1:0];
					rpms_pkg::CFG_OTHER_LOCK:  other_lock_q  <= cfg_data[rpms_pkg::TICK_W-1:0];
					rpms_pkg::CFG_RAMP_INC:    ramp_inc_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						unique case (op.kind)
							rpms_pkg::OP_TICK: begin
								// a pending estop drops to default once this tick is out
								if (estop_q) begin
									estop_q <= 1'b0;
									mode_q  <= rpms_pkg::M_DEFAULT;
								end
								if (ticks_q != rpms_pkg::TICK_SAT) begin
									ticks_q <= ticks_q + 16'd1;
								end
								loop_mode_q  <= estop_q ? rpms_pkg::M_DEFAULT : mode_q;
								loop_blend_q <= tick_moves;
								loop_stand_q <= mode_q == rpms_pkg::M_STAND;
								loop_frac_q  <= frac_q;
								if (tick_moves) begin
									frac_q <= frac_next;
								end
								if (tick_emits) begin
									st_q <= ST_TICK;
									j_q  <= '0;
								end
							end
							rpms_pkg::OP_WRITE: begin
								if (op.code == rpms_pkg::IN_REPORT) begin
									live_valid_q[JW'(op.joint)] <= 1'b1;
								end
							end
							rpms_pkg::OP_EVENT: begin
								if (op.code == rpms_pkg::IN_ESTOP) begin
									estop_q <= 1'b1;
								end
								if (pass) begin
									ticks_q <= '0;
								end
								mode_q    <= ev_mode;
								enabled_q <= ev_en;
								if (ev_zero) begin
									frac_q <= '0;
								end
								if (ev_snap) begin
									start_valid_q <= live_valid_q;
									st_q          <= ST_COPY;
									j_q           <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					if (slot_free) begin
						if (j_q == J_LAST) begin
							st_q <= ST_IDLE;
						end else begin
							j_q <= j_q + JW'(1);
						end
					end
				end
				ST_COPY: begin
					if (j_q == J_LAST) begin
						st_q <= ST_IDLE;
					end else begin
						j_q <= j_q + JW'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// blend: a + (b - a) * f / 2^16, rounded half up
	always_comb begin
		a_sel = '0;
		b_sel = '0;
		if (blend_s1) begin
			if (stand_s1) begin
				a_sel = lie_rd;
				b_sel = stand_rd;
			end else begin
				a_sel = start_valid_q[j_s1] ? start_rd : '0;
				b_sel = lie_rd;
			end
		end
	end

	assign tgt_sum = p_s3 + $signed({{3{a_s3[ANGLE_BITS-1]}}, a_s3, 16'h8000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			cp_v_s1 <= 1'b0;
		end else begin
			v_s1    <= issue_tick || issue_status;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			cp_v_s1 <= st_q == ST_COPY;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1    <= issue_status ? stat_meta : tick_meta;
		blend_s1   <= issue_tick && loop_blend_q;
		stand_s1   <= loop_stand_q;
		f_s1       <= loop_frac_q;
		j_s1       <= j_q;
		cp_addr_s1 <= j_q;
		meta_s2    <= meta_s1;
		a_s2       <= a_sel;
		d_s2       <= {b_sel[ANGLE_BITS-1], b_sel} - {a_sel[ANGLE_BITS-1], a_sel};
		f_s2       <= f_s1;
		meta_s3    <= meta_s2;
		a_s3       <= a_s2;
		p_s3       <= d_s2 * $signed({1'b0, f_s2});
	end

	// output queue
	assign oq_pop = commands.valid && commands.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (v_s3) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (v_s3 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !v_s3) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			oq_meta_q[oq_wr_q] <= meta_s3;
			oq_tgt_q[oq_wr_q]  <= tgt_sum[ANGLE_BITS+15:16];
		end
	end

	assign commands.valid                  = oq_cnt_q != '0;
	assign commands.is_status              = oq_meta_q[oq_rd_q].is_status;
	assign commands.joint_number           = oq_meta_q[oq_rd_q].joint_number;
	assign commands.target_angle           = oq_tgt_q[oq_rd_q];
	assign commands.stiffness              = oq_meta_q[oq_rd_q].stiffness;
	assign commands.damping_tenths         = oq_meta_q[oq_rd_q].damping_tenths;
	assign commands.last_of_run            = oq_meta_q[oq_rd_q].last_of_run;
	assign commands.current_mode           = oq_meta_q[oq_rd_q].current_mode;
	assign commands.control_enabled        = oq_meta_q[oq_rd_q].control_enabled;
	assign commands.restart_policy         = oq_meta_q[oq_rd_q].restart_policy;
	assign commands.clear_velocity_command = oq_meta_q[oq_rd_q].clear_velocity_command;

endmodule

>>> rtl/robot_pose_mode_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot pose mode sequencer
// Mode supervisor for a legged robot: lockout-gated mode events, joint
// position snapshots and ramp-blended lie/stand pose commands on each tick.
// ----------------------------------------------------------------------------
// Usage:
//  events   : input items (tick, position report, pose load, mode event).
//  commands : result items; a tick in default, lie or stand gives JOINT_COUNT
//             joint commands, an event gives one status item, the rest none.
//  cfg_*    : register writes, only while the block is idle.
//  A four-item front queue takes items while the back end is busy; results
//  leave through an eight-entry output queue, so a stalled receiver first
//  fills that queue, then holds the joint sweep, then the front queue.
//  Path: an item waits in the front queue; the back end then pushes its
//  results through the blend pipeline into the output queue.
//  Throughput: a tick holds the back end while it sweeps the joints, one
//  joint read and blended per cycle while the output queue has room; an
//  event that snapshots the live joints then holds it to copy the table.
//  Reset: default mode, control disabled, live and start angles read as zero,
//  lockout counter saturated; pose tables must be loaded before use.
// ----------------------------------------------------------------------------
module robot_pose_mode_sequencer #(
	parameter int JOINT_COUNT = 21,
	parameter int ANGLE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rpms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpms_pkg::CFG_DATA_W-1:0] cfg_data,
	rpms_in_if.sink                         events,
	rpms_out_if.source                      commands
);

	logic                         op_valid, op_ready;
	rpms_pkg::op_t                op;
	logic signed [ANGLE_BITS-1:0] op_angle;

	rpms_front #(.JOINT_COUNT(JOINT_COUNT), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op      (op),
		.op_angle(op_angle)
	);

	rpms_back #(.JOINT_COUNT(JOINT_COUNT), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.op_angle (op_angle),
		.commands (commands)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose mode sequencer testbench
// Drives ticks, joint reports, pose loads and mode events into the sequencer
// under several lockout and ramp settings, with random idling on both
// channels and one long receiver hold-off. A scoreboard keeps its own copy of
// the mode, lockout and blend state, predicts every joint command and status
// item, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int JOINTS        = 21;
	localparam int ANGLE_BITS    = 16;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int RUN_LIMIT_NS  = 1_000_000;

	// codes the block ignores
	localparam logic [rpms_pkg::CODE_W-1:0]     IN_SPARE_LO = 4'd12;
	localparam logic [rpms_pkg::CODE_W-1:0]     IN_SPARE_HI = 4'd15;
	localparam logic [rpms_pkg::CFG_DATA_W-1:0] LOCK_NEVER  = 17'(rpms_pkg::TICK_SAT);

	typedef struct packed {
		logic [rpms_pkg::CODE_W-1:0]  code;
		logic [rpms_pkg::JNUM_W-1:0]  joint;
		logic signed [ANGLE_BITS-1:0] angle;
	} event_item_t;

	typedef struct packed {
		logic                          is_status;
		logic [rpms_pkg::JNUM_W-1:0]   joint_number;
		logic signed [ANGLE_BITS-1:0]  target_angle;
		logic [rpms_pkg::STIFF_W-1:0]  stiffness;
		logic [rpms_pkg::DAMP_W-1:0]   damping_tenths;
		logic                          last_of_run;
		logic [rpms_pkg::MODE_W-1:0]   current_mode;
		logic                          control_enabled;
		logic                          restart_policy;
		logic                          clear_velocity_command;
	} cmd_t;

	class pose_scoreboard;
		logic [rpms_pkg::TICK_W-1:0] start_lock, switch_lock, other_lock;
		logic [rpms_pkg::FRAC_W-1:0] ramp_inc;
		logic [rpms_pkg::MODE_W-1:0] mode;
		logic                        enabled, estop_pend;
		logic [rpms_pkg::FRAC_W-1:0] frac;
		logic [rpms_pkg::TICK_W-1:0] ticks;
		logic signed [ANGLE_BITS-1:0] live [JOINTS];
		logic signed [ANGLE_BITS-1:0] start_pos [JOINTS];
		logic signed [ANGLE_BITS-1:0] lie_tab [JOINTS];
		logic signed [ANGLE_BITS-1:0] stand_tab [JOINTS];
		bit   lie_set [JOINTS];
		bit   stand_set [JOINTS];
		cmd_t expected_cmds [$];
		int   errors;

		function new();
			start_lock  = rpms_pkg::RST_START_LOCK;
			switch_lock = rpms_pkg::RST_SWITCH_LOCK;
			other_lock  = rpms_pkg::RST_OTHER_LOCK;
			ramp_inc    = rpms_pkg::RST_RAMP_INC;
			mode        = rpms_pkg::M_DEFAULT;
			enabled     = 1'b0;
			estop_pend  = 1'b0;
			frac        = '0;
			ticks       = rpms_pkg::TICK_SAT;
			errors      = 0;
			foreach (live[j]) begin
				live[j]      = '0;
				start_pos[j] = '0;
				lie_tab[j]   = '0;
				stand_tab[j] = '0;
				lie_set[j]   = 1'b0;
				stand_set[j] = 1'b0;
			end
		endfunction

		function void set_register(logic [rpms_pkg::CFG_IDX_W-1:0] idx,
				logic [rpms_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				rpms_pkg::CFG_START_LOCK:  start_lock  = data[rpms_pkg::TICK_W-1:0];
				rpms_pkg::CFG_SWITCH_LOCK: switch_lock = data[rpms_pkg::TICK_W-1:0];
				rpms_pkg::CFG_OTHER_LOCK:  other_lock  = data[rpms_pkg::TICK_W-1:0];
				rpms_pkg::CFG_RAMP_INC:    ramp_inc    = data;
				default: ;
			endcase
		endfunction

		// a tick in lie or stand must not read a pose entry never loaded;
		// hands back a load that fills the first gap
		function bit pose_gap(output event_item_t fix);
			int j;
			fix = '0;
			fix.angle = ANGLE_BITS'($urandom());
			if (mode != rpms_pkg::M_LIE && mode != rpms_pkg::M_STAND)
				return 1'b0;
			for (j = 0; j < JOINTS; j++) begin
				fix.joint = rpms_pkg::JNUM_W'(j);
				if (!lie_set[j]) begin
					fix.code = rpms_pkg::IN_LOAD_LIE;
					return 1'b1;
				end
				if (mode == rpms_pkg::M_STAND && !stand_set[j]) begin
					fix.code = rpms_pkg::IN_LOAD_STAND;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void add_cmd(logic st, logic [rpms_pkg::JNUM_W-1:0] j,
				logic signed [ANGLE_BITS-1:0] t, logic [rpms_pkg::STIFF_W-1:0] kp,
				logic [rpms_pkg::DAMP_W-1:0] kd, logic last, logic rs, logic cv);
			cmd_t c;
			c.is_status              = st;
			c.joint_number           = j;
			c.target_angle           = t;
			c.stiffness              = kp;
			c.damping_tenths         = kd;
			c.last_of_run            = last;
			c.current_mode           = mode;
			c.control_enabled        = enabled;
			c.restart_policy         = rs;
			c.clear_velocity_command = cv;
			expected_cmds = {expected_cmds, c};
		endfunction

		// (a*(1-f) + b*f) in Q.16, rounded half up
		function logic signed [ANGLE_BITS-1:0] ramp_target(logic signed [ANGLE_BITS-1:0] a,
				logic signed [ANGLE_BITS-1:0] b);
			longint s;
			s = longint'(a) * (longint'(rpms_pkg::FRAC_ONE) - longint'(frac)) +
				longint'(b) * longint'(frac);
			s = (s + 32768) >>> 16;
			return s[ANGLE_BITS-1:0];
		endfunction

		function void enter_lie();
			frac = '0;
			foreach (start_pos[j])
				start_pos[j] = live[j];
			mode = rpms_pkg::M_LIE;
		endfunction

		function void run_tick();
			logic [rpms_pkg::MODE_W-1:0]  m;
			logic [rpms_pkg::FRAC_W:0]    f;
			logic [rpms_pkg::DAMP_W-1:0]  kd;
			logic signed [ANGLE_BITS-1:0] t;
			int                           j;
			m = mode;
			// estop takes effect after this tick's commands, which still carry the new mode
			if (estop_pend) begin
				estop_pend = 1'b0;
				mode = rpms_pkg::M_DEFAULT;
			end
			if (m == rpms_pkg::M_DEFAULT) begin
				for (j = 0; j < JOINTS; j++)
					add_cmd(1'b0, rpms_pkg::JNUM_W'(j), '0, rpms_pkg::STIFF_OFF,
						rpms_pkg::DAMP_DEFAULT, j == JOINTS - 1, 1'b0, 1'b0);
			end else if (m == rpms_pkg::M_LIE || m == rpms_pkg::M_STAND) begin
				for (j = 0; j < JOINTS; j++) begin
					t = (m == rpms_pkg::M_LIE) ? ramp_target(start_pos[j], lie_tab[j])
						: ramp_target(lie_tab[j], stand_tab[j]);
					kd = (j == rpms_pkg::ANKLE_ROLL_L || j == rpms_pkg::ANKLE_ROLL_R) ?
						rpms_pkg::DAMP_ANKLE : rpms_pkg::DAMP_BODY;
					add_cmd(1'b0, rpms_pkg::JNUM_W'(j), t, rpms_pkg::STIFF_ON, kd,
						j == JOINTS - 1, 1'b0, 1'b0);
				end
				f = frac + ramp_inc;
				frac = (f > rpms_pkg::FRAC_ONE) ? rpms_pkg::FRAC_ONE : f[rpms_pkg::FRAC_W-1:0];
			end
			if (ticks != rpms_pkg::TICK_SAT)
				ticks = ticks + 1'b1;
		endfunction

		function void accept_event(event_item_t it);
			logic [rpms_pkg::MODE_W-1:0] m;
			logic [rpms_pkg::TICK_W-1:0] lock;
			logic                        rs, cv;
			m  = mode;
			rs = 1'b0;
			cv = 1'b0;
			case (it.code)
				rpms_pkg::IN_TICK: begin
					run_tick();
					return;
				end
				rpms_pkg::IN_REPORT, rpms_pkg::IN_LOAD_LIE, rpms_pkg::IN_LOAD_STAND: begin
					if (it.joint < JOINTS) begin
						if (it.code == rpms_pkg::IN_REPORT) begin
							live[it.joint] = it.angle;
						end else if (it.code == rpms_pkg::IN_LOAD_LIE) begin
							lie_tab[it.joint] = it.angle;
							lie_set[it.joint] = 1'b1;
						end else begin
							stand_tab[it.joint] = it.angle;
							stand_set[it.joint] = 1'b1;
						end
					end
					return;
				end
				rpms_pkg::IN_ESTOP: estop_pend = 1'b1;
				rpms_pkg::IN_START, rpms_pkg::IN_SWITCH, rpms_pkg::IN_WALK,
				rpms_pkg::IN_DANCE, rpms_pkg::IN_WALK12, rpms_pkg::IN_JUMP13,
				rpms_pkg::IN_POSITION: begin
					if (it.code == rpms_pkg::IN_START)
						lock = start_lock;
					else if (it.code == rpms_pkg::IN_SWITCH)
						lock = switch_lock;
					else
						lock = other_lock;
					if (ticks > lock) begin
						case (it.code)
							rpms_pkg::IN_START: begin
								if (!enabled) begin
									enabled = 1'b1;
									enter_lie();
								end else begin
									enabled = 1'b0;
									mode = rpms_pkg::M_DEFAULT;
								end
							end
							rpms_pkg::IN_SWITCH: begin
								if (enabled && m == rpms_pkg::M_STAND) begin
									enter_lie();
								end else if (enabled && m == rpms_pkg::M_LIE) begin
									frac = '0;
									mode = rpms_pkg::M_STAND;
								end
							end
							rpms_pkg::IN_WALK: begin
								if (m == rpms_pkg::M_STAND || m == rpms_pkg::M_WALK12 ||
										m == rpms_pkg::M_JUMP13) begin
									mode = rpms_pkg::M_WALK;
									rs = 1'b1;
								end else if (m == rpms_pkg::M_DANCE) begin
									mode = rpms_pkg::M_WALK;
									rs = 1'b1;
									cv = 1'b1;
								end
							end
							rpms_pkg::IN_DANCE: begin
								if (enabled && (m == rpms_pkg::M_STAND || m == rpms_pkg::M_WALK
										|| m == rpms_pkg::M_WALK12 || m == rpms_pkg::M_JUMP13)) begin
									mode = rpms_pkg::M_DANCE;
									rs = 1'b1;
									cv = 1'b1;
								end
							end
							rpms_pkg::IN_WALK12: begin
								if (m == rpms_pkg::M_STAND || m == rpms_pkg::M_WALK ||
										m == rpms_pkg::M_JUMP13) begin
									mode = rpms_pkg::M_WALK12;
									rs = 1'b1;
								end
							end
							rpms_pkg::IN_JUMP13: begin
								if (m == rpms_pkg::M_STAND || m == rpms_pkg::M_WALK ||
										m == rpms_pkg::M_WALK12) begin
									mode = rpms_pkg::M_JUMP13;
									rs = 1'b1;
								end
							end
							rpms_pkg::IN_POSITION: begin
								if (m == rpms_pkg::M_WALK || m == rpms_pkg::M_WALK12 ||
										m == rpms_pkg::M_JUMP13) begin
									mode = rpms_pkg::M_STAND;
								end else if (m == rpms_pkg::M_DANCE) begin
									mode = rpms_pkg::M_WALK;
									rs = 1'b1;
									cv = 1'b1;
								end else if (m == rpms_pkg::M_DEFAULT) begin
									enter_lie();
								end
							end
							default: ;
						endcase
						// a passing event restarts the count even if nothing changed
						ticks = '0;
					end
				end
				default: return;
			endcase
			add_cmd(1'b1, '0, '0, rpms_pkg::STIFF_OFF, rpms_pkg::DAMP_NONE, 1'b1, rs, cv);
		endfunction

		function void compare(string name, logic signed [31:0] want, logic signed [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_command(cmd_t got);
			cmd_t want;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected command, expected none actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			compare("is_status", 32'(want.is_status), 32'(got.is_status));
			compare("joint_number", 32'(want.joint_number), 32'(got.joint_number));
			compare("target_angle", 32'(want.target_angle), 32'(got.target_angle));
			compare("stiffness", 32'(want.stiffness), 32'(got.stiffness));
			compare("damping_tenths", 32'(want.damping_tenths), 32'(got.damping_tenths));
			compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
			compare("current_mode", 32'(want.current_mode), 32'(got.current_mode));
			compare("control_enabled", 32'(want.control_enabled), 32'(got.control_enabled));
			compare("restart_policy", 32'(want.restart_policy), 32'(got.restart_policy));
			compare("clear_velocity_command", 32'(want.clear_velocity_command),
				32'(got.clear_velocity_command));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [rpms_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rpms_pkg::CFG_DATA_W-1:0] cfg_data;

	rpms_in_if  #(.ANGLE_BITS(ANGLE_BITS)) ev_if ();
	rpms_out_if #(.ANGLE_BITS(ANGLE_BITS)) cmd_if ();

	robot_pose_mode_sequencer #(
		.JOINT_COUNT(JOINTS),
		.ANGLE_BITS (ANGLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.events   (ev_if),
		.commands (cmd_if)
	);

	pose_scoreboard sb = new();
	bit src_gaps;
	bit snk_gaps;
	bit hold_pending;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic event_item_t make_item(logic [rpms_pkg::CODE_W-1:0] c,
			logic [rpms_pkg::JNUM_W-1:0] j, logic signed [ANGLE_BITS-1:0] a);
		event_item_t it;
		it.code  = c;
		it.joint = j;
		it.angle = a;
		return it;
	endfunction

	// random items; the mode events are mostly ones that move the robot on from its present mode
	function automatic event_item_t random_event();
		logic [rpms_pkg::CODE_W-1:0] opts [$];
		event_item_t                 it;
		int                          r;
		r = $urandom_range(0, 99);
		it.joint = ($urandom_range(0, 9) == 0) ? rpms_pkg::JNUM_W'($urandom_range(JOINTS, 31))
			: rpms_pkg::JNUM_W'($urandom_range(0, JOINTS - 1));
		case ($urandom_range(0, 9))
			0: it.angle = 16'h7FFF;
			1: it.angle = 16'h8000;
			default: it.angle = ANGLE_BITS'($urandom());
		endcase
		case (sb.mode)
			rpms_pkg::M_DEFAULT: opts = {rpms_pkg::IN_START, rpms_pkg::IN_POSITION};
			rpms_pkg::M_LIE:     opts = {rpms_pkg::IN_SWITCH, rpms_pkg::IN_START};
			rpms_pkg::M_STAND:   opts = {rpms_pkg::IN_WALK, rpms_pkg::IN_DANCE,
				rpms_pkg::IN_WALK12, rpms_pkg::IN_JUMP13, rpms_pkg::IN_SWITCH};
			rpms_pkg::M_WALK:    opts = {rpms_pkg::IN_DANCE, rpms_pkg::IN_WALK12,
				rpms_pkg::IN_JUMP13, rpms_pkg::IN_POSITION};
			rpms_pkg::M_DANCE:   opts = {rpms_pkg::IN_WALK, rpms_pkg::IN_POSITION};
			rpms_pkg::M_WALK12:  opts = {rpms_pkg::IN_WALK, rpms_pkg::IN_JUMP13,
				rpms_pkg::IN_POSITION, rpms_pkg::IN_DANCE};
			default:             opts = {rpms_pkg::IN_WALK, rpms_pkg::IN_WALK12,
				rpms_pkg::IN_POSITION, rpms_pkg::IN_DANCE};
		endcase
		if (r < 40)
			it.code = rpms_pkg::IN_TICK;
		else if (r < 68)
			it.code = opts[$urandom_range(0, opts.size() - 1)];
		else if (r < 76)
			it.code = rpms_pkg::CODE_W'($urandom_range(rpms_pkg::IN_START,
				rpms_pkg::IN_POSITION));
		else if (r < 79)
			it.code = rpms_pkg::IN_ESTOP;
		else if (r < 88)
			it.code = rpms_pkg::IN_REPORT;
		else if (r < 95)
			it.code = $urandom_range(0, 1) ? rpms_pkg::IN_LOAD_LIE : rpms_pkg::IN_LOAD_STAND;
		else
			it.code = rpms_pkg::CODE_W'($urandom_range(IN_SPARE_LO, IN_SPARE_HI));
		return it;
	endfunction

	task automatic send(input event_item_t it);
		event_item_t fix;
		int          gap;
		if (it.code == rpms_pkg::IN_TICK && sb.pose_gap(fix))
			it = fix;
		gap = src_gaps ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			ev_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev_if.valid       <= 1'b1;
		ev_if.mode        <= it.code;
		ev_if.joint_index <= it.joint;
		ev_if.angle_value <= it.angle;
		do @(posedge clk); while (ev_if.ready !== 1'b1);
		sb.accept_event(it);
	endtask

	task automatic random_items(input int n);
		repeat (n) send(random_event());
	endtask

	// wait for the block to drain, including items that give no result
	task automatic settle();
		ev_if.valid <= 1'b0;
		while (sb.expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rpms_pkg::CFG_IDX_W-1:0] idx,
			input logic [rpms_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(input logic [rpms_pkg::CFG_DATA_W-1:0] s_lock,
			input logic [rpms_pkg::CFG_DATA_W-1:0] w_lock,
			input logic [rpms_pkg::CFG_DATA_W-1:0] o_lock,
			input logic [rpms_pkg::CFG_DATA_W-1:0] ramp);
		write_reg(rpms_pkg::CFG_START_LOCK, s_lock);
		write_reg(rpms_pkg::CFG_SWITCH_LOCK, w_lock);
		write_reg(rpms_pkg::CFG_OTHER_LOCK, o_lock);
		write_reg(rpms_pkg::CFG_RAMP_INC, ramp);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_pose_tables();
		int j;
		for (j = 0; j < JOINTS; j++) begin
			send(make_item(rpms_pkg::IN_LOAD_LIE, rpms_pkg::JNUM_W'(j),
				(j == 0) ? 16'h7FFF : (j == 1) ? 16'h8000 : ANGLE_BITS'($urandom())));
			send(make_item(rpms_pkg::IN_LOAD_STAND, rpms_pkg::JNUM_W'(j),
				(j == 0) ? 16'h8000 : (j == 1) ? 16'h7FFF : ANGLE_BITS'($urandom())));
		end
	endtask

	task automatic directed_items();
		send(make_item(rpms_pkg::IN_REPORT, 5'd0, 16'h7FFF));
		send(make_item(rpms_pkg::IN_REPORT, 5'd20, 16'h8000));
		send(make_item(rpms_pkg::IN_REPORT, 5'd31, 16'h5555));   // out of range, dropped
		send(make_item(rpms_pkg::IN_LOAD_STAND, 5'd21, 16'h1234));
		send(make_item(IN_SPARE_LO, '0, '0));
		send(make_item(IN_SPARE_HI, 5'd31, 16'hFFFF));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_POSITION, '0, '0));         // default into lie, snapshot
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));             // fraction now saturated
		send(make_item(rpms_pkg::IN_SWITCH, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_WALK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_DANCE, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_WALK12, '0, '0));           // not allowed from dance
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_WALK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_JUMP13, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_POSITION, '0, '0));
		send(make_item(rpms_pkg::IN_ESTOP, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
	endtask

	initial begin : command_sink
		int   stall;
		cmd_t got;
		cmd_if.ready = 1'b0;
		forever begin
			stall = snk_gaps ? $urandom_range(0, 3) : 0;
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall != 0) begin
				cmd_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cmd_if.ready <= 1'b1;
			do @(posedge clk); while (cmd_if.valid !== 1'b1);
			got.is_status              = cmd_if.is_status;
			got.joint_number           = cmd_if.joint_number;
			got.target_angle           = cmd_if.target_angle;
			got.stiffness              = cmd_if.stiffness;
			got.damping_tenths         = cmd_if.damping_tenths;
			got.last_of_run            = cmd_if.last_of_run;
			got.current_mode           = cmd_if.current_mode;
			got.control_enabled        = cmd_if.control_enabled;
			got.restart_policy         = cmd_if.restart_policy;
			got.clear_velocity_command = cmd_if.clear_velocity_command;
			sb.check_command(got);
		end
	end

	initial begin : stimulus
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		ev_if.valid       = 1'b0;
		ev_if.mode        = rpms_pkg::IN_TICK;
		ev_if.joint_index = '0;
		ev_if.angle_value = '0;
		src_gaps          = 1'b1;
		snk_gaps          = 1'b1;
		hold_pending      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: the saturated counter lets the first event through, the long
		// lockouts then turn the later mode events away; the estop is not gated
		load_pose_tables();
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_START, '0, '0));
		send(make_item(rpms_pkg::IN_SWITCH, '0, '0));
		send(make_item(rpms_pkg::IN_WALK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_ESTOP, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		send(make_item(rpms_pkg::IN_TICK, '0, '0));
		settle();

		configure(17'd0, 17'd0, 17'd0, rpms_pkg::FRAC_ONE);
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		directed_items();
		settle();

		configure(17'd1, 17'd2, 17'd0, 17'($urandom_range(1, 2000)));
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
		random_items(30);
		settle();

		// receiver holds off while items keep coming, filling the block
		configure(17'd0, 17'd0, 17'd0, 17'd1);
		src_gaps = 1'b0;
		hold_pending = 1'b1;
		random_items(30);
		settle();

		configure(LOCK_NEVER, LOCK_NEVER, LOCK_NEVER, 17'd65535);
		src_gaps = 1'b1;
		snk_gaps = 1'b0;
		random_items(10);
		settle();

		configure(17'd3, 17'd1, 17'd2, 17'($urandom_range(1, 65536)));
		snk_gaps = 1'b1;
		random_items(30);
		settle();

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
rtl/rpms_pkg.sv
rtl/rpms_if.sv
rtl/rpms_ram.sv
rtl/rpms_front.sv
rtl/rpms_back.sv
rtl/robot_pose_mode_sequencer.sv
sim/tb_top.sv
